/* rtl/core/npq_pkg.sv */
// Package for the note priority stack: sizes, the empty-note code,
// operation codes and sequencer states. No dependencies.
package npq_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 8;
  localparam int ADDR_W     = 7;

  localparam logic [NOTE_W-1:0] NOTE_NONE = 8'd128;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UNLINK,
    ST_UNLINK2,
    ST_PUSH1,
    ST_PUSH2,
    ST_SCAN_START,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/npq_if.sv */
// Valid/ready channel interfaces for the note priority stack.
// Depends on npq_pkg.
interface npq_in_if import npq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [NOTE_W-1:0] note;
  modport source (output valid, kind, note, input ready);
  modport sink   (input valid, kind, note, output ready);
endinterface

interface npq_out_if import npq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] popped_note;
  logic              was_present;
  logic [NOTE_W-1:0] newest_note;
  logic [NOTE_W-1:0] oldest_note;
  logic [NOTE_W-1:0] lowest_note;
  logic [NOTE_W-1:0] highest_note;
  logic              stack_empty;
  modport source (output valid, popped_note, was_present, newest_note, oldest_note,
                  lowest_note, highest_note, stack_empty, input ready);
  modport sink   (input valid, popped_note, was_present, newest_note, oldest_note,
                  lowest_note, highest_note, stack_empty, output ready);
endinterface

interface npq_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/npq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/note_priority_stack.sv */
// Top level of the note priority stack: sequencer, link RAMs, result register.
// Depends on npq_pkg, npq_if and npq_ram.
//
// Held notes form a doubly linked list in two 128-entry link RAMs, newest on
// top. One transaction runs through a read-modify-write sequencer. A clear,
// an ignored note, a remove of a note not held or a pop of an empty stack
// goes from READ straight to DONE. A remove or a pop passes READ, UNLINK and
// UNLINK2; a push of a new note passes READ, PUSH1 and PUSH2, and a push of a
// held note passes READ, UNLINK, PUSH1 and PUSH2. The next transaction is
// taken once the sequencer is back in idle after the result is loaded. When
// a removal takes away the lowest or highest note, the list is walked at one
// RAM read per remaining note. Writing cfg data 1 runs the same walk; no
// transaction is taken meanwhile. Per-entry valid bits clear both RAMs at
// once on reset and on clear, so there is no clearing pass.
module note_priority_stack import npq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  npq_in_if.sink    in_ch,
  npq_out_if.source out_ch,
  npq_cfg_if.sink   cfg_ch
);

  state_t state_r, state_nxt;

  op_t               kind_r;
  logic [NOTE_W-1:0] note_r;
  logic [ADDR_W-1:0] tgt_r;
  logic [NOTE_W-1:0] older_r, newer_r, cur_r, popped_r;
  logic              present_r, from_cfg_r, track_r;
  logic [NOTE_W-1:0] top_r, tail_r, min_r, max_r;

  logic [NOTE_COUNT-1:0] n2o_vld_r, o2n_vld_r;
  logic                  n2o_rv_r, o2n_rv_r;

  logic              n2o_we, o2n_we;
  logic [ADDR_W-1:0] n2o_waddr, o2n_waddr, n2o_raddr, o2n_raddr;
  logic [NOTE_W-1:0] n2o_wdata, o2n_wdata, n2o_rdata, o2n_rdata;
  logic [NOTE_W-1:0] n2o_rd, o2n_rd;

  logic in_fire, cfg_fire, out_load, present, held;

  npq_ram #(.WIDTH(NOTE_W), .DEPTH(NOTE_COUNT)) u_n2o_ram (
    .clk(clk), .we(n2o_we), .waddr(n2o_waddr), .wdata(n2o_wdata),
    .raddr(n2o_raddr), .rdata(n2o_rdata)
  );

  npq_ram #(.WIDTH(NOTE_W), .DEPTH(NOTE_COUNT)) u_o2n_ram (
    .clk(clk), .we(o2n_we), .waddr(o2n_waddr), .wdata(o2n_wdata),
    .raddr(o2n_raddr), .rdata(o2n_rdata)
  );

  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == ST_DONE) && (!out_ch.valid || out_ch.ready);

  assign n2o_rd  = n2o_rv_r ? n2o_rdata : NOTE_NONE;
  assign o2n_rd  = o2n_rv_r ? o2n_rdata : NOTE_NONE;
  assign present = !note_r[7] && ((top_r == note_r) || !o2n_rd[7]);

  always_comb begin
    unique case (kind_r)
      OP_PUSH:   held = present;
      OP_REMOVE: held = present;
      OP_POP:    held = !top_r[7];
      OP_CLEAR:  held = 1'b0;
      default:   held = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          state_nxt = cfg_ch.data ? ST_SCAN_START : ST_IDLE;
        end else if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (held) begin
          state_nxt = ST_UNLINK;
        end else if (kind_r == OP_PUSH && !note_r[7]) begin
          state_nxt = ST_PUSH1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_UNLINK: state_nxt = (kind_r == OP_PUSH) ? ST_PUSH1 : ST_UNLINK2;
      ST_UNLINK2: begin
        if (track_r && !top_r[7] &&
            ({1'b0, tgt_r} == min_r || {1'b0, tgt_r} == max_r)) begin
          state_nxt = ST_SCAN_START;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUSH1: state_nxt = ST_PUSH2;
      ST_PUSH2: state_nxt = ST_DONE;
      ST_SCAN_START: begin
        if (top_r[7]) begin
          state_nxt = from_cfg_r ? ST_IDLE : ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (n2o_rd[7]) begin
          state_nxt = from_cfg_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM ports
  always_comb begin
    n2o_we    = 1'b0;
    o2n_we    = 1'b0;
    n2o_waddr = tgt_r;
    o2n_waddr = tgt_r;
    n2o_wdata = NOTE_NONE;
    o2n_wdata = NOTE_NONE;
    n2o_raddr = in_ch.note[ADDR_W-1:0];
    o2n_raddr = in_ch.note[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (op_t'(in_ch.kind) == OP_POP) n2o_raddr = top_r[ADDR_W-1:0];
      end
      ST_UNLINK: begin
        if (!older_r[7]) begin
          o2n_we    = 1'b1;
          o2n_waddr = older_r[ADDR_W-1:0];
          o2n_wdata = newer_r;
        end
        if (!newer_r[7]) begin
          n2o_we    = 1'b1;
          n2o_waddr = newer_r[ADDR_W-1:0];
          n2o_wdata = older_r;
        end
      end
      ST_UNLINK2: begin
        n2o_we = 1'b1;
        o2n_we = 1'b1;
      end
      ST_PUSH1: begin
        n2o_we    = 1'b1;
        n2o_wdata = top_r;
        o2n_we    = 1'b1;
      end
      ST_PUSH2: begin
        if (!top_r[7]) begin
          o2n_we    = 1'b1;
          o2n_waddr = top_r[ADDR_W-1:0];
          o2n_wdata = {1'b0, tgt_r};
        end
      end
      ST_SCAN_START: n2o_raddr = top_r[ADDR_W-1:0];
      ST_SCAN:       n2o_raddr = n2o_rd[ADDR_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      track_r    <= 1'b1;
      top_r      <= NOTE_NONE;
      tail_r     <= NOTE_NONE;
      min_r      <= NOTE_NONE;
      max_r      <= NOTE_NONE;
      n2o_vld_r  <= '0;
      o2n_vld_r  <= '0;
      n2o_rv_r   <= 1'b0;
      o2n_rv_r   <= 1'b0;
      from_cfg_r <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n2o_rv_r <= n2o_vld_r[n2o_raddr];
      o2n_rv_r <= o2n_vld_r[o2n_raddr];
      if (n2o_we) n2o_vld_r[n2o_waddr] <= 1'b1;
      if (o2n_we) o2n_vld_r[o2n_waddr] <= 1'b1;
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_fire) begin
            track_r    <= cfg_ch.data;
            from_cfg_r <= 1'b1;
            min_r      <= NOTE_NONE;
            max_r      <= NOTE_NONE;
          end else if (in_fire) begin
            from_cfg_r <= 1'b0;
          end
        end
        ST_READ: begin
          if (kind_r == OP_CLEAR) begin
            n2o_vld_r <= '0;
            o2n_vld_r <= '0;
            top_r     <= NOTE_NONE;
            tail_r    <= NOTE_NONE;
            min_r     <= NOTE_NONE;
            max_r     <= NOTE_NONE;
          end
        end
        ST_UNLINK: begin
          if (older_r[7]) tail_r <= newer_r;
          if (newer_r[7]) top_r  <= older_r;
        end
        ST_UNLINK2: begin
          if (track_r && top_r[7]) begin
            min_r <= NOTE_NONE;
            max_r <= NOTE_NONE;
          end
        end
        ST_PUSH2: begin
          if (top_r[7]) tail_r <= {1'b0, tgt_r};
          top_r <= {1'b0, tgt_r};
          if (track_r) begin
            if ({1'b0, tgt_r} < min_r) min_r <= {1'b0, tgt_r};
            if (max_r == NOTE_NONE || {1'b0, tgt_r} > max_r) max_r <= {1'b0, tgt_r};
          end
        end
        ST_SCAN_START: begin
          min_r <= NOTE_NONE;
          max_r <= NOTE_NONE;
        end
        ST_SCAN: begin
          if (cur_r < min_r) min_r <= cur_r;
          if (max_r == NOTE_NONE || cur_r > max_r) max_r <= cur_r;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= op_t'(in_ch.kind);
      note_r <= in_ch.note;
    end
    if (state_r == ST_READ) begin
      present_r <= present;
      older_r   <= n2o_rd;
      newer_r   <= (kind_r == OP_POP) ? NOTE_NONE : o2n_rd;
      tgt_r     <= (kind_r == OP_POP) ? top_r[ADDR_W-1:0] : note_r[ADDR_W-1:0];
      popped_r  <= (kind_r == OP_POP) ? top_r : NOTE_NONE;
    end
    if (state_r == ST_SCAN_START) cur_r <= top_r;
    if (state_r == ST_SCAN)       cur_r <= n2o_rd;
    if (out_load) begin
      out_ch.popped_note  <= popped_r;
      out_ch.was_present  <= present_r;
      out_ch.newest_note  <= top_r;
      out_ch.oldest_note  <= tail_r;
      out_ch.lowest_note  <= min_r;
      out_ch.highest_note <= max_r;
      out_ch.stack_empty  <= top_r[7];
    end
  end

  a_top_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (top_r[7] == tail_r[7]))
    else $error("top and tail disagree on empty list");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && min_r != NOTE_NONE) |-> (min_r <= max_r))
    else $error("lowest note above highest note");

  a_untracked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !track_r) |-> (min_r == NOTE_NONE && max_r == NOTE_NONE))
    else $error("extremes held while not tracked");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_DONE))
    else $error("result register loaded outside done state");

endmodule

/* dv/npq_tb_pkg.sv */
// Shared testbench types for the note priority stack environment.
// Depends on npq_pkg.
package npq_tb_pkg;
  import npq_pkg::*;

  typedef struct packed {
    logic [NOTE_W-1:0] popped_note;
    logic              was_present;
    logic [NOTE_W-1:0] newest_note;
    logic [NOTE_W-1:0] oldest_note;
    logic [NOTE_W-1:0] lowest_note;
    logic [NOTE_W-1:0] highest_note;
    logic              stack_empty;
  } note_report_t;
endpackage

/* dv/tb_top.sv */
// Self-checking testbench for note_priority_stack: directed and random note
// operations checked against a behavioral stack model. Depends on npq_pkg,
// npq_tb_pkg, npq_if and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import npq_pkg::*;
  import npq_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic clk;
  logic rst_n;

  npq_in_if  in_ch ();
  npq_out_if out_ch ();
  npq_cfg_if cfg_ch ();

  note_priority_stack DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // stack model state
  logic [NOTE_W-1:0] older_of [NOTE_COUNT];
  logic [NOTE_W-1:0] newer_of [NOTE_COUNT];
  logic [NOTE_W-1:0] top_n, tail_n, lo_n, hi_n;
  logic              extremes_on;

  note_report_t expected_reports[$];
  int  mismatches;
  int  reports_seen;
  int  idle_cycles;
  bit  calm_mode;
  bit  hold_off;
  bit  timed_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit note_held(logic [NOTE_W-1:0] n);
    if (n >= NOTE_COUNT) return 1'b0;
    return top_n == n || newer_of[n] != NOTE_NONE;
  endfunction

  function automatic void rescan_bounds();
    logic [NOTE_W-1:0] cur;
    cur  = top_n;
    lo_n = NOTE_NONE;
    hi_n = NOTE_NONE;
    for (int i = 0; i < NOTE_COUNT && cur != NOTE_NONE; i++) begin
      if (lo_n == NOTE_NONE || cur < lo_n) lo_n = cur;
      if (hi_n == NOTE_NONE || cur > hi_n) hi_n = cur;
      cur = older_of[cur];
    end
  endfunction

  function automatic void clear_stack();
    for (int i = 0; i < NOTE_COUNT; i++) begin
      older_of[i] = NOTE_NONE;
      newer_of[i] = NOTE_NONE;
    end
    top_n = NOTE_NONE;
    tail_n = NOTE_NONE;
    lo_n = NOTE_NONE;
    hi_n = NOTE_NONE;
  endfunction

  function automatic void detach_note(logic [NOTE_W-1:0] n);
    logic [NOTE_W-1:0] o, w;
    o = older_of[n];
    w = newer_of[n];
    if (o != NOTE_NONE) newer_of[o] = w;
    else tail_n = w;
    if (w != NOTE_NONE) older_of[w] = o;
    else top_n = o;
    older_of[n] = NOTE_NONE;
    newer_of[n] = NOTE_NONE;
  endfunction

  function automatic void bounds_after_drop(logic [NOTE_W-1:0] n);
    if (!extremes_on) return;
    if (top_n == NOTE_NONE) begin
      lo_n = NOTE_NONE;
      hi_n = NOTE_NONE;
    end else if (n == lo_n || n == hi_n) begin
      rescan_bounds();
    end
  endfunction

  function automatic void apply_extremes_setting(logic on);
    extremes_on = on;
    if (on) rescan_bounds();
    else begin
      lo_n = NOTE_NONE;
      hi_n = NOTE_NONE;
    end
  endfunction

  function automatic note_report_t predict_report(op_t op, logic [NOTE_W-1:0] n);
    note_report_t r;
    logic [NOTE_W-1:0] popped;
    bit held;
    popped = NOTE_NONE;
    held   = note_held(n);
    case (op)
      OP_PUSH: begin
        if (n < NOTE_COUNT) begin
          if (held) detach_note(n);
          older_of[n] = top_n;
          newer_of[n] = NOTE_NONE;
          if (top_n != NOTE_NONE) newer_of[top_n] = n;
          else tail_n = n;
          top_n = n;
          if (extremes_on) begin
            if (lo_n == NOTE_NONE || n < lo_n) lo_n = n;
            if (hi_n == NOTE_NONE || n > hi_n) hi_n = n;
          end
        end
      end
      OP_REMOVE: begin
        if (held) begin
          detach_note(n);
          bounds_after_drop(n);
        end
      end
      OP_POP: begin
        if (top_n != NOTE_NONE) begin
          popped = top_n;
          detach_note(popped);
          bounds_after_drop(popped);
        end
      end
      default: clear_stack();
    endcase
    r.popped_note  = popped;
    r.was_present  = held;
    r.newest_note  = top_n;
    r.oldest_note  = tail_n;
    r.lowest_note  = extremes_on ? lo_n : NOTE_NONE;
    r.highest_note = extremes_on ? hi_n : NOTE_NONE;
    r.stack_empty  = top_n == NOTE_NONE;
    return r;
  endfunction

  task automatic send_note_op(op_t op, logic [NOTE_W-1:0] n);
    while (!calm_mode && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= op;
    in_ch.note  <= n;
    do @(posedge clk); while (!in_ch.ready);
    expected_reports.push_back(predict_report(op, n));
  endtask

  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_extremes(logic on);
    drain_reports();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= on;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_extremes_setting(on);
  endtask

  function automatic logic [NOTE_W-1:0] pick_note();
    int r;
    r = $urandom_range(99);
    if (r < 6) return NOTE_W'($urandom_range(255, 128));
    if (r < 60) return NOTE_W'($urandom_range(15));
    return NOTE_W'($urandom_range(127));
  endfunction

  task automatic run_random_ops(int count);
    int r;
    op_t op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) op = OP_PUSH;
      else if (r < 75) op = OP_REMOVE;
      else if (r < 97) op = OP_POP;
      else op = OP_CLEAR;
      send_note_op(op, pick_note());
    end
  endtask

  task automatic test_directed_edges();
    send_note_op(OP_POP, 8'd0);
    send_note_op(OP_REMOVE, 8'd5);
    send_note_op(OP_PUSH, 8'd0);
    send_note_op(OP_PUSH, 8'd0);
    send_note_op(OP_PUSH, 8'd127);
    send_note_op(OP_PUSH, 8'd128);
    send_note_op(OP_PUSH, 8'd255);
    send_note_op(OP_REMOVE, 8'd200);
    send_note_op(OP_PUSH, 8'd64);
    send_note_op(OP_PUSH, 8'd0);
    send_note_op(OP_REMOVE, 8'd127);
    send_note_op(OP_POP, 8'd64);
    send_note_op(OP_REMOVE, 8'd64);
    send_note_op(OP_PUSH, 8'd85);
    send_note_op(OP_PUSH, 8'd42);
    send_note_op(OP_CLEAR, 8'd85);
    send_note_op(OP_POP, 8'd170);
    send_note_op(OP_PUSH, 8'd1);
    send_note_op(OP_POP, 8'd1);
  endtask

  task automatic test_extremes_toggle();
    write_extremes(1'b0);
    run_random_ops(60);
    write_extremes(1'b1);
    run_random_ops(60);
    write_extremes(1'b0);
    write_extremes(1'b1);
  endtask

  task automatic test_random_calm();
    calm_mode = 1'b1;
    run_random_ops(120);
    calm_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random_ops(20);
    join
  endtask

  task automatic test_random_mix();
    run_random_ops(270);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && (calm_mode || $urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    note_report_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.popped_note, out_ch.was_present, out_ch.newest_note,
              out_ch.oldest_note, out_ch.lowest_note, out_ch.highest_note,
              out_ch.stack_empty};
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        exp_r = expected_reports.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p actual %p", reports_seen, exp_r, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("watchdog expired with %0d results outstanding", expected_reports.size());
    $display("** note_priority_stack: FAILED **");
    $finish;
  end

  initial begin
    calm_mode    = 1'b0;
    hold_off     = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= OP_PUSH;
    in_ch.note   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 1'b0;
    clear_stack();
    extremes_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_extremes_toggle();
    test_random_calm();
    test_backpressure();
    test_random_mix();
    drain_reports();
    $display("Covered push, remove, pop and clear on invalid, held and absent notes,");
    $display("extreme tracking on and off, and %0d checked results.", reports_seen);
    if (mismatches == 0 && !timed_out) begin
      $display("** note_priority_stack: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** note_priority_stack: FAILED **");
    end
    $finish;
  end
endmodule
